FILE: src/mecf_pkg.sv
package mecf_pkg;

  localparam int MAX_LINE_PIXELS_DEF = 1024;
  localparam int ELEMENT_SIZE        = 5;
  localparam int HALF_EL             = ELEMENT_SIZE / 2;

  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int LEVEL_W  = 9;
  localparam int ROW_W    = 14;
  localparam int CFG_W    = 13;

  localparam int FIFO_DEPTH  = 8;
  localparam int PIPE_STAGES = 5;
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_BINARIZE_LEVEL = 2'd2;
  localparam logic [1:0] REG_DETECT_MODE    = 2'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic MODE_EDGE   = 1'b0;
  localparam logic MODE_CORNER = 1'b1;

  localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST    = 11'd640;
  localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST   = 13'd480;
  localparam logic [LEVEL_W-1:0]  BINARIZE_LEVEL_RST = 9'h1FF;
  localparam logic                DETECT_MODE_RST    = MODE_CORNER;

  localparam logic [7:0] PIX_MAX = 8'hFF;

  typedef logic [7:0]  pix_t;
  typedef pix_t [4:0]  pix5_t;
  typedef pix_t [2:0]  pix3_t;
  typedef logic [15:0] clo_t;
  typedef clo_t [4:0]  clo5_t;

  typedef struct packed {
    logic [7:0] value;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic       emit;
    logic       fend;
    logic       mode;
    logic [4:0] j_row_ok;
    logic [4:0] j_col_ok;
    logic [4:0] k_row_ok;
    logic [4:0] k_col_ok;
  } pipe_ctl_t;

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max5(input pix5_t v);
    return max2(max2(max2(v[0], v[1]), max2(v[2], v[3])), v[4]);
  endfunction

  function automatic pix_t min5(input pix5_t v);
    return min2(min2(min2(v[0], v[1]), min2(v[2], v[3])), v[4]);
  endfunction

  function automatic pix_t max3(input pix3_t v);
    return max2(max2(v[0], v[1]), v[2]);
  endfunction

  function automatic pix_t min3(input pix3_t v);
    return min2(min2(v[0], v[1]), v[2]);
  endfunction

endpackage

FILE: src/mecf_line_ram.sv
module mecf_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q_r;
  logic [DATA_W-1:0] fwd_data_r;
  logic              fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r     <= mem[rd_addr];
    fwd_data_r <= wr_data;
  end

  // same-address read and write in one cycle returns the new word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

endmodule

FILE: src/mecf_out_fifo.sv
module mecf_out_fifo
  import mecf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  result_t          wr_data,
  input  logic             rd_en,
  output result_t          rd_data,
  output logic [CNT_W-1:0] count
);

  localparam int PW = $clog2(FIFO_DEPTH);

  result_t          mem_r [FIFO_DEPTH];
  logic [PW-1:0]    wptr_r;
  logic [PW-1:0]    rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= wptr_r + PW'(1);
      end
      if (rd_en) begin
        rptr_r <= rptr_r + PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign rd_data = mem_r[rptr_r];
  assign count   = cnt_r;

endmodule

FILE: src/morphological_edge_corner_filter.sv
// Morphological edge / corner filter for a raster stream of 8-bit grey pixels. One item
// (pixel or drain beat) is taken every clock while the input is not stalled; each stepping
// item runs through a fixed five-stage pipeline (line memory read, 5x5 image window,
// dilation stage, closing line memory read, 5x5 closing window, erosion, threshold) into
// an 8-entry result queue. The input side stalls only when the result queue holds more
// than two beats. A frame's first result comes with its item number W+1 (edge mode) or
// 4W+4 (corner mode); after the last pixel that many drain beats flush the rest, the last
// one flagged frame_end. Width, height and mode are latched at the first pixel of a
// frame, the threshold level applies at once. The two line memories (one read and one
// write port each, one column per beat) need no clearing after reset: entries outside the
// current frame are never used.
module morphological_edge_corner_filter
  import mecf_pkg::*;
#(
  parameter int MAX_LINE_PIXELS = MAX_LINE_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [7:0]         in_pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_value,
  output logic               out_frame_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_LINE_PIXELS);
  localparam int FW = $clog2(MAX_LINE_PIXELS + 1);
  localparam int WU = FW + 3;
  localparam int RW = ROW_W;

  // configuration
  logic [WIDTH_W-1:0]  image_width_r;
  logic [HEIGHT_W-1:0] image_height_r;
  logic [LEVEL_W-1:0]  binarize_level_r;
  logic                detect_mode_r;

  // frame state
  logic                frame_active_r, frame_active_nxt;
  logic [FW-1:0]       fr_w_r, fr_w_nxt;
  logic [HEIGHT_W-1:0] fr_h_r, fr_h_nxt;
  logic                fr_mode_r, fr_mode_nxt;
  logic [WU-1:0]       wu_r, wu_nxt;
  logic [CW-1:0]       tcol_r, tcol_nxt, jcol_r, jcol_nxt, kcol_r, kcol_nxt;
  logic [RW-1:0]       trow_r, trow_nxt, jrow_r, jrow_nxt, krow_r, krow_nxt;
  logic                k_on_r, k_on_nxt;

  logic                accept, pix_done, start, step, emit, kend;
  logic [FW-1:0]       w_clamp, w_cur;
  logic [HEIGHT_W-1:0] h_clamp, h_cur;
  logic                mode_cur;
  logic [WU-1:0]       d1, delay, t_cur;
  logic [CW-1:0]       tcol_cur, jcol_cur, kcol_cur;
  logic [RW-1:0]       trow_cur, jrow_cur, krow_cur;
  logic                k_on_cur;

  // pipeline
  pipe_ctl_t           s0_ctl, s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r, s5_ctl_r;
  logic [7:0]          s1_px_r;
  logic [CW-1:0]       s1_col_r, s2_col_r, s3_col_r;
  logic [31:0]         img_q;
  pix5_t               img_tap;
  pix5_t               iw_r [5];
  pix5_t               dil [5];
  pix5_t               row2, col2, dg0, dg1;
  pix3_t               e_hi [3];
  pix3_t               e_lo [3];
  pix3_t               e_hi_m, e_lo_m;
  pix_t                cmax, xmax, emax, emin;
  clo_t                s3_mid_r;
  pix_t                s3_edge_r, s4_edge_r, s5_edge_r;
  logic [63:0]         cl_q;
  clo5_t               cl_tap;
  clo5_t               cw_r [5];
  pix5_t               dv [5];
  pix5_t               sv [5];
  pix5_t               dmins, smins;
  pix_t                s5_dmin_r, s5_smin_r;
  pix_t                diff, raw, final_v;
  logic                enq, deq;
  result_t             enq_data, deq_data;
  logic [CNT_W-1:0]    fifo_cnt;

  function automatic logic [CW+RW-1:0] adv(input logic [CW-1:0] col, input logic [RW-1:0] row,
                                           input logic [FW-1:0] w);
    if (FW'(col) == w - FW'(1)) begin
      return {CW'(0), row + RW'(1)};
    end
    return {col + CW'(1), row};
  endfunction

  function automatic logic [4:0] row_ok(input logic [RW-1:0] row, input logic [HEIGHT_W-1:0] h);
    logic [4:0]  ok;
    logic [RW:0] rs;
    for (int i = 0; i < 5; i++) begin
      rs    = {1'b0, row} + (RW+1)'(i);
      ok[i] = (rs >= (RW+1)'(HALF_EL)) && (rs < (RW+1)'(h) + (RW+1)'(HALF_EL));
    end
    return ok;
  endfunction

  function automatic logic [4:0] col_ok(input logic [CW-1:0] col, input logic [FW-1:0] w);
    logic [4:0]  ok;
    logic [FW:0] cs;
    for (int i = 0; i < 5; i++) begin
      cs    = (FW+1)'(col) + (FW+1)'(i);
      ok[i] = (cs >= (FW+1)'(HALF_EL)) && (cs < (FW+1)'(w) + (FW+1)'(HALF_EL));
    end
    return ok;
  endfunction

  // configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r    <= IMAGE_WIDTH_RST;
      image_height_r   <= IMAGE_HEIGHT_RST;
      binarize_level_r <= BINARIZE_LEVEL_RST;
      detect_mode_r    <= DETECT_MODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    image_width_r    <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:   image_height_r   <= cfg_data[HEIGHT_W-1:0];
        REG_BINARIZE_LEVEL: binarize_level_r <= cfg_data[LEVEL_W-1:0];
        REG_DETECT_MODE:    detect_mode_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // frame control
  assign in_ready = fifo_cnt <= CNT_W'(FIFO_DEPTH - PIPE_STAGES - 1);
  assign accept   = in_valid && in_ready;
  assign pix_done = trow_r >= RW'(fr_h_r);
  assign start    = accept && (in_opcode == OP_PIXEL) && (!frame_active_r || pix_done);
  assign step     = accept && ((in_opcode == OP_PIXEL) || (frame_active_r && pix_done));

  always_comb begin
    if (image_width_r == '0) begin
      w_clamp = FW'(1);
    end else if (32'(image_width_r) > 32'(MAX_LINE_PIXELS)) begin
      w_clamp = FW'(MAX_LINE_PIXELS);
    end else begin
      w_clamp = FW'(image_width_r);
    end
    h_clamp = (image_height_r == '0) ? HEIGHT_W'(1) : image_height_r;

    w_cur    = start ? w_clamp : fr_w_r;
    h_cur    = start ? h_clamp : fr_h_r;
    mode_cur = start ? detect_mode_r : fr_mode_r;
    d1       = (WU'(w_cur) << 1) + WU'(2);
    delay    = (mode_cur == MODE_CORNER) ? (d1 << 1) : (WU'(w_cur) + WU'(1));

    t_cur    = start ? '0 : wu_r;
    tcol_cur = start ? '0 : tcol_r;
    trow_cur = start ? '0 : trow_r;
    jcol_cur = (t_cur == d1) ? '0 : jcol_r;
    jrow_cur = (t_cur == d1) ? '0 : jrow_r;
    kcol_cur = (t_cur == delay) ? '0 : kcol_r;
    krow_cur = (t_cur == delay) ? '0 : krow_r;
    k_on_cur = start ? 1'b0 : k_on_r;
    emit     = k_on_cur || (t_cur == delay);
    kend     = emit && (FW'(kcol_cur) == w_cur - FW'(1))
                    && (krow_cur == RW'(h_cur) - RW'(1));

    s0_ctl.valid    = step;
    s0_ctl.emit     = emit;
    s0_ctl.fend     = kend;
    s0_ctl.mode     = mode_cur;
    s0_ctl.j_row_ok = row_ok(jrow_cur, h_cur);
    s0_ctl.j_col_ok = col_ok(jcol_cur, w_cur);
    s0_ctl.k_row_ok = row_ok(krow_cur, h_cur);
    s0_ctl.k_col_ok = col_ok(kcol_cur, w_cur);
  end

  always_comb begin
    frame_active_nxt     = frame_active_r;
    fr_w_nxt             = fr_w_r;
    fr_h_nxt             = fr_h_r;
    fr_mode_nxt          = fr_mode_r;
    wu_nxt               = wu_r;
    {tcol_nxt, trow_nxt} = {tcol_r, trow_r};
    {jcol_nxt, jrow_nxt} = {jcol_r, jrow_r};
    {kcol_nxt, krow_nxt} = {kcol_r, krow_r};
    k_on_nxt             = k_on_r;
    if (step) begin
      fr_w_nxt             = w_cur;
      fr_h_nxt             = h_cur;
      fr_mode_nxt          = mode_cur;
      frame_active_nxt     = !kend;
      wu_nxt               = (t_cur > delay) ? t_cur : t_cur + WU'(1);
      {tcol_nxt, trow_nxt} = adv(tcol_cur, trow_cur, w_cur);
      {jcol_nxt, jrow_nxt} = adv(jcol_cur, jrow_cur, w_cur);
      {kcol_nxt, krow_nxt} = adv(kcol_cur, krow_cur, w_cur);
      k_on_nxt             = emit && !kend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r <= 1'b0;
      fr_w_r         <= FW'(1);
      fr_h_r         <= HEIGHT_W'(1);
      fr_mode_r      <= DETECT_MODE_RST;
      wu_r           <= '0;
      tcol_r         <= '0;
      trow_r         <= '0;
      jcol_r         <= '0;
      jrow_r         <= '0;
      kcol_r         <= '0;
      krow_r         <= '0;
      k_on_r         <= 1'b0;
    end else begin
      frame_active_r <= frame_active_nxt;
      fr_w_r         <= fr_w_nxt;
      fr_h_r         <= fr_h_nxt;
      fr_mode_r      <= fr_mode_nxt;
      wu_r           <= wu_nxt;
      tcol_r         <= tcol_nxt;
      trow_r         <= trow_nxt;
      jcol_r         <= jcol_nxt;
      jrow_r         <= jrow_nxt;
      kcol_r         <= kcol_nxt;
      krow_r         <= krow_nxt;
      k_on_r         <= k_on_nxt;
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
      s5_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s0_ctl;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      s4_ctl_r <= s3_ctl_r;
      s5_ctl_r <= s4_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_px_r  <= in_pixel;
    s1_col_r <= tcol_cur;
    s2_col_r <= s1_col_r;
    s3_col_r <= s2_col_r;
  end

  // image line memory: four previous lines per column
  mecf_line_ram #(
    .DEPTH  (MAX_LINE_PIXELS),
    .ADDR_W (CW),
    .DATA_W (32)
  ) u_img_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (tcol_cur),
    .wr_en   (s1_ctl_r.valid),
    .wr_addr (s1_col_r),
    .wr_data ({img_q[23:0], s1_px_r}),
    .rd_data (img_q)
  );

  always_comb begin
    img_tap[4] = s1_px_r;
    img_tap[3] = img_q[7:0];
    img_tap[2] = img_q[15:8];
    img_tap[1] = img_q[23:16];
    img_tap[0] = img_q[31:24];
  end

  always_ff @(posedge clk) begin
    if (s1_ctl_r.valid) begin
      for (int r = 0; r < 5; r++) begin
        iw_r[r] <= {img_tap[r], iw_r[r][4:1]};
      end
    end
  end

  // dilation by cross and by x, plus the 3x3 gradient
  always_comb begin
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        dil[r][c] = (s2_ctl_r.j_row_ok[r] && s2_ctl_r.j_col_ok[c]) ? iw_r[r][c] : '0;
      end
    end
    for (int i = 0; i < 5; i++) begin
      row2[i] = dil[2][i];
      col2[i] = dil[i][2];
      dg0[i]  = dil[i][i];
      dg1[i]  = dil[i][4-i];
    end
    cmax = max2(max5(row2), max5(col2));
    xmax = max2(max5(dg0), max5(dg1));

    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (s2_ctl_r.k_row_ok[r+1] && s2_ctl_r.k_col_ok[c+1]) begin
          e_hi[r][c] = iw_r[r+2][c+2];
          e_lo[r][c] = iw_r[r+2][c+2];
        end else begin
          e_hi[r][c] = '0;
          e_lo[r][c] = PIX_MAX;
        end
      end
    end
    for (int r = 0; r < 3; r++) begin
      e_hi_m[r] = max3(e_hi[r]);
      e_lo_m[r] = min3(e_lo[r]);
    end
    emax = max3(e_hi_m);
    emin = min3(e_lo_m);
  end

  always_ff @(posedge clk) begin
    s3_mid_r  <= {xmax, cmax};
    s3_edge_r <= emax - emin;
    s4_edge_r <= s3_edge_r;
    s5_edge_r <= s4_edge_r;
  end

  // closing line memory
  mecf_line_ram #(
    .DEPTH  (MAX_LINE_PIXELS),
    .ADDR_W (CW),
    .DATA_W (64)
  ) u_clo_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (s2_col_r),
    .wr_en   (s3_ctl_r.valid),
    .wr_addr (s3_col_r),
    .wr_data ({cl_q[47:0], s3_mid_r}),
    .rd_data (cl_q)
  );

  always_comb begin
    cl_tap[4] = s3_mid_r;
    cl_tap[3] = cl_q[15:0];
    cl_tap[2] = cl_q[31:16];
    cl_tap[1] = cl_q[47:32];
    cl_tap[0] = cl_q[63:48];
  end

  always_ff @(posedge clk) begin
    if (s3_ctl_r.valid) begin
      for (int r = 0; r < 5; r++) begin
        cw_r[r] <= {cl_tap[r], cw_r[r][4:1]};
      end
    end
  end

  // erosion: diamond on the cross result, square on the x result
  always_comb begin
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (s4_ctl_r.k_row_ok[r] && s4_ctl_r.k_col_ok[c]) begin
          sv[r][c] = cw_r[r][c][15:8];
          if (((r > 2) ? r - 2 : 2 - r) + ((c > 2) ? c - 2 : 2 - c) <= HALF_EL) begin
            dv[r][c] = cw_r[r][c][7:0];
          end else begin
            dv[r][c] = PIX_MAX;
          end
        end else begin
          sv[r][c] = PIX_MAX;
          dv[r][c] = PIX_MAX;
        end
      end
    end
    for (int r = 0; r < 5; r++) begin
      dmins[r] = min5(dv[r]);
      smins[r] = min5(sv[r]);
    end
  end

  always_ff @(posedge clk) begin
    s5_dmin_r <= min5(dmins);
    s5_smin_r <= min5(smins);
  end

  // final value and threshold
  always_comb begin
    diff    = (s5_smin_r > s5_dmin_r) ? s5_smin_r - s5_dmin_r : s5_dmin_r - s5_smin_r;
    raw     = (s5_ctl_r.mode == MODE_CORNER) ? diff : s5_edge_r;
    final_v = raw;
    if (!binarize_level_r[LEVEL_W-1] && (binarize_level_r[7:0] != '0)) begin
      final_v = (raw > binarize_level_r[7:0]) ? '0 : PIX_MAX;
    end
    enq                = s5_ctl_r.valid && s5_ctl_r.emit;
    enq_data.value     = final_v;
    enq_data.frame_end = s5_ctl_r.fend;
  end

  mecf_out_fifo u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (enq),
    .wr_data (enq_data),
    .rd_en   (deq),
    .rd_data (deq_data),
    .count   (fifo_cnt)
  );

  assign out_valid     = fifo_cnt != '0;
  assign deq           = out_valid && out_ready;
  assign out_value     = deq_data.value;
  assign out_frame_end = deq_data.frame_end;

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    (enq && !deq) |-> (fifo_cnt < CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    (step && kend) |=> !frame_active_r)
    else $error("frame still active after last result");

  a_center_col: assert property (@(posedge clk) disable iff (!rst_n)
    k_on_r |-> (FW'(kcol_r) < fr_w_r))
    else $error("output column beyond line width");

endmodule

FILE: verif/morphological_edge_corner_filter_tb.sv
module morphological_edge_corner_filter_tb
  import mecf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 8192;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_opcode = OP_PIXEL;
  logic [7:0]       in_pixel = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_value;
  logic             out_frame_end;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  morphological_edge_corner_filter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
    .out_frame_end(out_frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // filter state mirror
  logic [7:0]          img_mem [RING];
  logic [15:0]         clo_mem [RING];
  logic [WIDTH_W-1:0]  reg_width = IMAGE_WIDTH_RST;
  logic [HEIGHT_W-1:0] reg_height = IMAGE_HEIGHT_RST;
  logic [LEVEL_W-1:0]  reg_level = BINARIZE_LEVEL_RST;
  logic                reg_mode = DETECT_MODE_RST;
  bit                  frame_on;
  int                  in_pos, fw = 1, fh = 1, fn = 1;
  logic                fmode = MODE_CORNER;

  result_t expected_q [$];
  int      errors;
  int      items_sent;
  int      burst_left;
  int      cyc;

  initial forever #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic bit in_img(int r, int c);
    return r >= 0 && c >= 0 && r < fh && c < fw;
  endfunction

  function automatic int addr(int r, int c);
    return (r * fw + c) % RING;
  endfunction

  function automatic void dilate_at(int j);
    int r, c, cm, xm, v;
    r = j / fw;
    c = j % fw;
    cm = 0;
    xm = 0;
    for (int dr = -HALF_EL; dr <= HALF_EL; dr++) begin
      for (int dc = -HALF_EL; dc <= HALF_EL; dc++) begin
        if (in_img(r + dr, c + dc)) begin
          v = img_mem[addr(r + dr, c + dc)];
          if ((dr == 0 || dc == 0) && v > cm) cm = v;
          if ((dr == dc || dr == -dc) && v > xm) xm = v;
        end
      end
    end
    clo_mem[j % RING] = {xm[7:0], cm[7:0]};
  endfunction

  function automatic int corner_at(int k);
    int r, c, dmin, smin, lo, hi;
    r = k / fw;
    c = k % fw;
    dmin = 255;
    smin = 255;
    for (int dr = -HALF_EL; dr <= HALF_EL; dr++) begin
      for (int dc = -HALF_EL; dc <= HALF_EL; dc++) begin
        if (in_img(r + dr, c + dc)) begin
          lo = clo_mem[addr(r + dr, c + dc)][7:0];
          hi = clo_mem[addr(r + dr, c + dc)][15:8];
          if ((dr < 0 ? -dr : dr) + (dc < 0 ? -dc : dc) <= HALF_EL && lo < dmin) dmin = lo;
          if (hi < smin) smin = hi;
        end
      end
    end
    return smin > dmin ? smin - dmin : dmin - smin;
  endfunction

  function automatic int gradient_at(int k);
    int r, c, mx, mn, v;
    r = k / fw;
    c = k % fw;
    mx = 0;
    mn = 255;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (in_img(r + dr, c + dc)) begin
          v = img_mem[addr(r + dr, c + dc)];
          if (v > mx) mx = v;
          if (v < mn) mn = v;
        end
      end
    end
    return mx - mn;
  endfunction

  function automatic void filter_step(int t);
    int d1, dly, k, v, lvl;
    result_t res;
    d1 = HALF_EL * fw + HALF_EL;
    dly = (fmode == MODE_CORNER) ? 2 * d1 : fw + 1;
    if (fmode == MODE_CORNER && t >= d1 && t - d1 < fn) dilate_at(t - d1);
    if (t < dly || t - dly >= fn) return;
    k = t - dly;
    v = (fmode == MODE_CORNER) ? corner_at(k) : gradient_at(k);
    lvl = $signed(reg_level);
    if (lvl > 0) v = (v > lvl) ? 0 : 255;
    res.value = v[7:0];
    res.frame_end = (k == fn - 1);
    expected_q.push_back(res);
    if (k == fn - 1) frame_on = 0;
  endfunction

  function automatic void predict_item(logic op, logic [7:0] px);
    if (op == OP_PIXEL) begin
      if (!frame_on || in_pos >= fn) begin
        fw = (reg_width == 0) ? 1 : int'(reg_width);
        if (fw > MAX_LINE_PIXELS_DEF) fw = MAX_LINE_PIXELS_DEF;
        fh = (reg_height == 0) ? 1 : int'(reg_height);
        fn = fw * fh;
        fmode = reg_mode;
        in_pos = 0;
        frame_on = 1;
      end
      img_mem[in_pos % RING] = px;
      filter_step(in_pos);
      in_pos++;
    end else if (frame_on && in_pos >= fn) begin
      filter_step(in_pos);
      in_pos++;
    end
  endfunction

  task automatic report(string what, int got, int exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected beat", out_value, -1);
      end else begin
        exp = expected_q.pop_front();
        if (out_value !== exp.value) report("value", out_value, exp.value);
        if (out_frame_end !== exp.frame_end) report("frame_end", out_frame_end, exp.frame_end);
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case ((cyc / 300) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= $urandom_range(0, 1);
      default: out_ready <= (cyc % 7) >= 2;
    endcase
  end

  task automatic send_item(logic op, logic [7:0] px);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_pixel <= px;
    do @(posedge clk); while (!in_ready);
    predict_item(op, px);
    items_sent++;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMAGE_WIDTH:    reg_width = val[WIDTH_W-1:0];
      REG_IMAGE_HEIGHT:   reg_height = val[HEIGHT_W-1:0];
      REG_BINARIZE_LEVEL: reg_level = val[LEVEL_W-1:0];
      default:            reg_mode = val[0];
    endcase
  endtask

  task automatic configure(int w, int h, int lvl, logic mode);
    wait_quiet();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_BINARIZE_LEVEL, lvl & 9'h1FF);
    write_reg(REG_DETECT_MODE, mode);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return PIX_MAX;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // pixels of one frame (stray drains mixed in per stray_pct), then drains; max_drains < 0 drains to frame end
  task automatic send_frame(int max_drains, int stray_pct);
    int n, d;
    n = (reg_width == 0 ? 1 : (reg_width > MAX_LINE_PIXELS_DEF ? MAX_LINE_PIXELS_DEF
        : int'(reg_width))) * (reg_height == 0 ? 1 : int'(reg_height));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < stray_pct) send_item(OP_DRAIN, $urandom_range(0, 255));
      send_item(OP_PIXEL, pick_pixel());
    end
    d = 0;
    while (frame_on && (max_drains < 0 || d < max_drains)) begin
      send_item(OP_DRAIN, $urandom_range(0, 255));
      d++;
    end
  endtask

  task automatic test_edge_basic();
    configure(4, 3, -1, MODE_EDGE);
    send_item(OP_DRAIN, 8'hFF);
    send_frame(-1, 15);
    send_item(OP_DRAIN, 8'h00);
  endtask

  task automatic test_corner_basic();
    configure(5, 5, -1, MODE_CORNER);
    send_frame(-1, 0);
    configure(6, 4, -1, MODE_CORNER);
    send_frame(-1, 10);
  endtask

  task automatic test_binarize();
    int lvls[5] = '{1, 128, 255, 0, -256};
    foreach (lvls[i]) begin
      configure(3, 3, lvls[i], MODE_EDGE);
      send_frame(-1, 0);
      configure(5, 3, lvls[i], MODE_CORNER);
      send_frame(-1, 0);
    end
  endtask

  task automatic test_extreme_sizes();
    configure(0, 0, -1, MODE_EDGE);
    send_frame(-1, 0);
    configure(0, 0, -1, MODE_CORNER);
    send_frame(-1, 0);
    configure(2047, 1, -1, MODE_EDGE);
    send_frame(12, 0);
    configure(9, 2, 40, MODE_CORNER);
    send_frame(-1, 0);
    configure(1, 120, -1, MODE_EDGE);
    send_frame(-1, 0);
    configure(7, 1, -1, MODE_CORNER);
    send_frame(-1, 0);
  endtask

  task automatic test_frame_abort();
    configure(4, 4, -1, MODE_CORNER);
    send_frame(9, 0);
    send_frame(-1, 0);
  endtask

  task automatic test_random_frames();
    int r;
    while (items_sent < 1950) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: r = -1;
          1: r = 0;
          2: r = -$urandom_range(1, 256);
          default: r = $urandom_range(1, 255);
        endcase
        configure($urandom_range(0, 15) == 0 ? $urandom_range(0, 2047) % 13 : $urandom_range(1, 8),
                  $urandom_range(0, 6), r, $urandom_range(0, 1));
      end
      r = $urandom_range(0, 9);
      if (r < 8) send_frame(-1, 0);
      else if (r == 8) send_frame($urandom_range(0, 6), 0);
      else send_frame(-1, 8);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_basic();
    test_corner_basic();
    test_binarize();
    test_extreme_sizes();
    test_frame_abort();
    test_random_frames();
    wait_quiet();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: morphological_edge_corner_filter.f
src/mecf_pkg.sv
src/mecf_line_ram.sv
src/mecf_out_fifo.sv
src/morphological_edge_corner_filter.sv
verif/morphological_edge_corner_filter_tb.sv
